// ----- hw/rtl/smpq_pkg.sv -----
// shared types and constants for the sorted min priority queue
// no dependencies; used by smpq_cell and sorted_min_priority_queue_core
package smpq_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int ELEMENT_W   = 32;
   localparam int PRIO_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int OCCUPANCY_W = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [ELEMENT_W-1:0] element;
      logic signed [PRIO_W-1:0]    prio;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      do_insert;
      logic      do_remove;
      entry_type new_entry;
   } cell_ctrl_type;

   // where a cell sits relative to the current fill level
   typedef struct packed {
      logic occupied;
      logic at_tail;
   } cell_pos_type;

endpackage

// ----- hw/rtl/smpq_cell.sv -----
// one slot of the sorted row: holds an entry, compares against the new
// priority and shifts right on insert or left on remove; uses smpq_pkg
module smpq_cell (
   input  logic                    clock,
   input  smpq_pkg::cell_ctrl_type ctrl,
   input  smpq_pkg::cell_pos_type  pos,
   input  smpq_pkg::entry_type     left_entry,
   input  logic                    left_ge,
   input  smpq_pkg::entry_type     right_entry,
   output smpq_pkg::entry_type     entry,
   output logic                    ge
);
   import smpq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // stored priority at or above the incoming one: this slot moves right
   assign ge    = pos.occupied && (entry_ff.prio >= ctrl.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert && (ge || pos.at_tail)) begin
         entry_in = left_ge ? left_entry : ctrl.new_entry;
      end else if (ctrl.do_remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- hw/rtl/sorted_min_priority_queue_core.sv -----
// top level of the sorted min priority queue: a row of smpq_cell slots,
// the fill counter and the response register; uses smpq_pkg
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   kind, element, priority_req
//   rsp       out         rsp_valid/rsp_stall   status, out_element, out_priority, occupancy
//
// one request per cycle while req is not stalled; every cell compares and shifts in the same cycle,
// and the response is registered in the cycle after the request is taken.
// a new request is taken while the response register is empty or being read.
// reset clears the fill count and the response valid; slot contents need none.
// rsp_stall holds the response and stalls req until it is taken.
module sorted_min_priority_queue_core #(
   parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic signed [smpq_pkg::ELEMENT_W-1:0] req_element,
   input  logic signed [smpq_pkg::PRIO_W-1:0]    req_priority_req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [smpq_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [smpq_pkg::ELEMENT_W-1:0] rsp_out_element,
   output logic signed [smpq_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic [smpq_pkg::OCCUPANCY_W-1:0]      rsp_occupancy
);
   import smpq_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   status_type                       rsp_status_ff;
   status_type                       rsp_status_in;
   logic signed [ELEMENT_W-1:0]      rsp_element_ff;
   logic signed [ELEMENT_W-1:0]      rsp_element_in;
   logic signed [PRIO_W-1:0]         rsp_prio_ff;
   logic signed [PRIO_W-1:0]         rsp_prio_in;
   logic [OCCUPANCY_W-1:0]           rsp_occupancy_ff;
   logic [OCCUPANCY_W-1:0]           rsp_occupancy_in;

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   entry_type            cell_entry [CAPACITY];
   logic [CAPACITY-1:0]  cell_ge;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == COUNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign ctrl.do_insert           = accept && (req_kind == KIND_INSERT) && !full;
   assign ctrl.do_remove           = accept && (req_kind == KIND_REMOVE) && !empty;
   assign ctrl.new_entry.element   = req_element;
   assign ctrl.new_entry.prio      = req_priority_req;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_pos_type pos;
      entry_type    left_entry;
      logic         left_ge;
      entry_type    right_entry;

      assign pos.occupied = (COUNT_W'(i) < count_ff);
      assign pos.at_tail  = (COUNT_W'(i) == count_ff);

      if (i == 0) begin : g_head
         assign left_entry = cell_entry[i];
         assign left_ge    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      smpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .pos         (pos),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.do_insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.do_remove) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_element_in   = rsp_element_ff;
      rsp_prio_in      = rsp_prio_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      if (accept) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = STATUS_OK;
         rsp_element_in   = '0;
         rsp_prio_in      = '0;
         rsp_occupancy_in = OCCUPANCY_W'(count_in);
         if (req_kind == KIND_INSERT) begin
            if (full) begin
               rsp_status_in = STATUS_OVERFLOW;
            end
         end else if (empty) begin
            rsp_status_in  = STATUS_UNDERFLOW;
            rsp_element_in = '1;
            rsp_prio_in    = '1;
         end else begin
            rsp_element_in = cell_entry[0].element;
            rsp_prio_in    = cell_entry[0].prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_element_ff   <= rsp_element_in;
      rsp_prio_ff      <= rsp_prio_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_element  = rsp_element_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;

endmodule

// ----- test/tb.sv -----
// self-checking testbench for sorted_min_priority_queue_core
// keeps its own sorted queue to predict every response; needs smpq_pkg and the core
`timescale 1ns / 1ps

module tb;
   import smpq_pkg::*;

   localparam int DEPTH     = DEFAULT_CAPACITY;
   localparam int PHASE_LEN = 420;

   typedef struct {
      logic                        kind;
      logic signed [ELEMENT_W-1:0] element;
      logic signed [PRIO_W-1:0]    prio;
      bit                          drain_first;
   } request_type;

   typedef struct {
      status_type                  status;
      logic signed [ELEMENT_W-1:0] element;
      logic signed [PRIO_W-1:0]    prio;
      logic [OCCUPANCY_W-1:0]      occupancy;
   } response_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_kind = KIND_INSERT;
   logic signed [ELEMENT_W-1:0] req_element = '0;
   logic signed [PRIO_W-1:0]    req_priority_req = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [ELEMENT_W-1:0] rsp_out_element;
   logic signed [PRIO_W-1:0]    rsp_out_priority;
   logic [OCCUPANCY_W-1:0]      rsp_occupancy;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   request_type  driven_request;

   // sorted copy of the queue contents, head at index 0
   entry_type   sorted_entries[DEPTH];
   int unsigned fill_level = 0;

   int accepted_count = 0;
   int responses_seen = 0;
   int error_count    = 0;
   int insert_count   = 0;
   int remove_count   = 0;
   int overflow_count = 0;
   int underflow_count = 0;
   int peak_fill      = 0;

   sorted_min_priority_queue_core #(.CAPACITY(DEPTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_element     (req_element),
      .req_priority_req(req_priority_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_element (rsp_out_element),
      .rsp_out_priority(rsp_out_priority),
      .rsp_occupancy   (rsp_occupancy)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int sender_idle_pct();
      if (accepted_count < PHASE_LEN) return 16;
      if (accepted_count < 2 * PHASE_LEN) return 62;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_count < PHASE_LEN) return 62;
      if (accepted_count < 2 * PHASE_LEN) return 16;
      return 0;
   endfunction

   // updates the sorted copy and returns the response the request should get
   function automatic response_type apply_request(request_type r);
      response_type resp;
      int unsigned  slot;
      resp.status  = STATUS_OK;
      resp.element = '0;
      resp.prio    = '0;
      if (r.kind == KIND_INSERT) begin
         if (fill_level >= DEPTH) begin
            resp.status = STATUS_OVERFLOW;
         end else begin
            slot = fill_level;
            // newer entry goes ahead of equal priorities
            while (slot > 0 && $signed(sorted_entries[slot-1].prio) >= $signed(r.prio)) begin
               sorted_entries[slot] = sorted_entries[slot-1];
               slot--;
            end
            sorted_entries[slot].element = r.element;
            sorted_entries[slot].prio    = r.prio;
            fill_level++;
         end
      end else begin
         if (fill_level == 0) begin
            resp.status  = STATUS_UNDERFLOW;
            resp.element = '1;
            resp.prio    = '1;
         end else begin
            resp.element = sorted_entries[0].element;
            resp.prio    = sorted_entries[0].prio;
            for (int i = 0; i + 1 < fill_level; i++)
               sorted_entries[i] = sorted_entries[i+1];
            fill_level--;
         end
      end
      resp.occupancy = fill_level[OCCUPANCY_W-1:0];
      return resp;
   endfunction

   task automatic report_mismatch(string what);
      if (error_count < 40)
         $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic queue_request(logic kind, int element, int prio, bit drain_first);
      request_type r;
      r.kind        = kind;
      r.element     = element;
      r.prio        = PRIO_W'(prio);
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endtask

   function automatic logic signed [PRIO_W-1:0] pick_priority();
      int unsigned sel;
      sel = $urandom_range(9);
      // narrow range half the time so equal priorities are common
      if (sel < 5) return PRIO_W'($signed($urandom_range(6)) - 3);
      if (sel == 5) begin
         case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return '1;
         endcase
      end
      return PRIO_W'($urandom);
   endfunction

   function automatic logic signed [ELEMENT_W-1:0] pick_element();
      case ($urandom_range(15))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -1;
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      request_type nxt;
      bit          accepted_now;
      bit          launch;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted_now = req_valid && !req_stall;
         if (accepted_now) begin
            expected_responses.push_back(apply_request(driven_request));
            accepted_count <= accepted_count + 1;
            if (driven_request.kind == KIND_INSERT) insert_count++;
            else remove_count++;
            if (fill_level > peak_fill) peak_fill = fill_level;
         end
         if (!req_valid || !req_stall) begin
            launch = 1'b0;
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               // hold off until every response so far is back
               if (!pending_requests[0].drain_first ||
                   (!accepted_now && responses_seen == accepted_count))
                  launch = 1'b1;
            end
            if (launch) begin
               nxt = pending_requests.pop_front();
               driven_request   = nxt;
               req_valid        <= 1'b1;
               req_kind         <= nxt.kind;
               req_element      <= nxt.element;
               req_priority_req <= nxt.prio;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen <= responses_seen + 1;
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_responses.pop_front();
               if (want.status == STATUS_OVERFLOW) overflow_count++;
               if (want.status == STATUS_UNDERFLOW) underflow_count++;
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_out_element !== want.element)
                  report_mismatch($sformatf("element %0d, expected %0d",
                                            rsp_out_element, want.element));
               if (rsp_out_priority !== want.prio)
                  report_mismatch($sformatf("priority %0d, expected %0d",
                                            rsp_out_priority, want.prio));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_occupancy, want.occupancy));
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
   end

   initial begin
      int burst_len;
      int insert_pct;
      int total;
      bit first_burst;

      // directed: empty remove, extremes, equal priorities, fill, overflow
      queue_request(KIND_REMOVE, 0, 0, 1'b0);
      queue_request(KIND_INSERT, 32'sh7fff_ffff, 0, 1'b0);
      queue_request(KIND_INSERT, 32'sh8000_0000, 32767, 1'b0);
      queue_request(KIND_INSERT, -1, -32768, 1'b0);
      queue_request(KIND_INSERT, 0, -1, 1'b0);
      queue_request(KIND_INSERT, 5, 0, 1'b0);
      queue_request(KIND_INSERT, 6, 0, 1'b0);
      queue_request(KIND_INSERT, 7, 32767, 1'b0);
      queue_request(KIND_INSERT, 8, -32768, 1'b0);
      queue_request(KIND_INSERT, 9, 1, 1'b0);
      queue_request(KIND_INSERT, 10, -2, 1'b0);
      queue_request(KIND_INSERT, 11, 3, 1'b0);
      queue_request(KIND_INSERT, 12, -4, 1'b0);
      queue_request(KIND_INSERT, 13, 1, 1'b0);
      queue_request(KIND_INSERT, 14, 1, 1'b0);
      queue_request(KIND_INSERT, 15, 2, 1'b0);
      queue_request(KIND_INSERT, 16, -2, 1'b0);
      queue_request(KIND_INSERT, 99, -5, 1'b0);
      queue_request(KIND_REMOVE, -1, -1, 1'b0);
      queue_request(KIND_REMOVE, 32'sh7fff_ffff, 32767, 1'b0);
      queue_request(KIND_REMOVE, 0, 0, 1'b0);

      // random bursts leaning toward fill or drain so both ends are hit often
      total = pending_requests.size();
      first_burst = 1'b1;
      while (total < 1220) begin
         case ($urandom_range(2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
         endcase
         burst_len = $urandom_range(40, 8);
         for (int i = 0; i < burst_len; i++) begin
            queue_request(($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE,
                          pick_element(), int'(pick_priority()),
                          i == 0 && (first_burst || $urandom_range(7) == 0));
            first_burst = 1'b0;
         end
         total += burst_len;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || responses_seen != accepted_count);
      repeat (8) @(negedge clock);

      if (expected_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_responses.size()));

      $display("ran %0d requests (%0d inserts, %0d removes), %0d overflows, %0d underflows",
               accepted_count, insert_count, remove_count, overflow_count, underflow_count);
      $display("peak fill %0d of %0d, with stalls on either side and none", peak_fill, DEPTH);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", expected_responses.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_min_priority_queue_core.sv
test/tb.sv
